/* hw/rtl/wsmt_pkg.sv */
package wsmt_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // one connection entry, also used as the latched lookup key
    typedef struct packed {
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [31:0] saddr;
        logic [15:0] dport;
        logic [31:0] daddr;
    } t_entry;

    // match score, 0 to 4
    typedef logic [2:0] t_score;

endpackage

/* hw/rtl/wildcard_socket_match_table.sv */
// Wildcard socket match table: an ordered table of 5-tuple connection entries.
// Command channel: a beat is taken on a rising edge with start high and busy
// low; the operation and key fields are sampled there. busy stays high until
// the command is finished, so only one command is in flight.
// Result channel: o_valid is high for exactly one cycle with o_status and
// o_result_slot; the receiver must take it then, it cannot stall the block.
// How each operation is carried out, from accept to the strobe:
//   add    : a one-slot-per-cycle scan of the valid bits up to the lowest free
//            slot (answered straight from idle if the table is full)
//   remove : the rank renumbering walk over every slot, one rank memory read
//            and write per cycle (answered straight from idle if the slot is free)
//   find   : the scoring walk over every slot, one entry memory read per
//            cycle through a single compare and score unit
//   unknown operation: answered straight from idle
// A new command can be accepted in the cycle the strobe is shown.
// Reset (synchronous, active low) clears the valid bits, the entry count and
// the sequencer; entry contents and ranks are left as they are and are only
// read for valid slots, so no clearing pass is needed.
module wildcard_socket_match_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_key_protocol,
    input  logic [15:0] i_key_sport,
    input  logic [31:0] i_key_saddr,
    input  logic [15:0] i_key_dport,
    input  logic [31:0] i_key_daddr,
    input  logic [3:0]  i_slot_handle,
    input  logic [2:0]  i_full_score,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_result_slot
);

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = SW + 4;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ADD_SCAN  = 3'd1;
    localparam logic [2:0] S_REM_CAP   = 3'd2;
    localparam logic [2:0] S_REM_WALK  = 3'd3;
    localparam logic [2:0] S_FIND_WALK = 3'd4;

    // table storage
    wsmt_pkg::t_entry ent_mem  [TABLE_DEPTH];
    logic [SW-1:0]    rank_mem [TABLE_DEPTH];
    wsmt_pkg::t_entry r_ent_rd;
    logic [SW-1:0]    r_rank_rd;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0]          r_count;

    // sequencer and walk pipeline
    logic [2:0]       r_state;
    logic [CW-1:0]    r_idx;
    logic             r_pend;
    logic [SW-1:0]    r_pidx;

    // latched command
    wsmt_pkg::t_entry r_key;
    wsmt_pkg::t_score r_full;
    logic [SW-1:0]    r_rem_slot;
    logic [SW-1:0]    r_rem_rank;

    // find bookkeeping
    logic             r_hit_full;
    logic [SW-1:0]    r_full_rank;
    logic [SW-1:0]    r_full_slot;
    logic             r_hit_best;
    wsmt_pkg::t_score r_best_score;
    logic [SW-1:0]    r_best_rank;
    logic [SW-1:0]    r_best_slot;

    // result register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [3:0]       r_out_slot;

    logic             accept;
    logic [HW-1:0]    handle_x;
    logic             handle_ok;
    logic [SW-1:0]    rd_addr;
    logic             walk_in_range;
    logic             rank_we;
    logic [SW-1:0]    rank_wa;
    logic [SW-1:0]    rank_wd;
    logic             ent_we;
    logic             scan_free;
    logic             n_match;
    wsmt_pkg::t_score n_score;
    logic             n_take_full;
    logic             n_take_best;

    assign accept    = start && !busy;
    assign handle_x  = {{SW{1'b0}}, i_slot_handle};
    assign handle_ok = (handle_x < HW'(TABLE_DEPTH)) && r_valid[handle_x[SW-1:0]];
    assign walk_in_range = r_idx < CW'(TABLE_DEPTH);
    assign scan_free = !r_valid[r_idx[SW-1:0]];

    // read address: handle while idle (rank of the slot to remove), else walk index
    always_comb begin
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            if (handle_x < HW'(TABLE_DEPTH)) begin
                rd_addr = handle_x[SW-1:0];
            end
        end else if (walk_in_range) begin
            rd_addr = r_idx[SW-1:0];
        end
    end

    // memory write port selection
    always_comb begin
        ent_we  = (r_state == S_ADD_SCAN) && scan_free;
        rank_we = 1'b0;
        rank_wa = r_idx[SW-1:0];
        rank_wd = r_count[SW-1:0];
        if (ent_we) begin
            rank_we = 1'b1;
        end else if (r_state == S_REM_WALK && r_pend && r_valid[r_pidx]
                     && r_rank_rd > r_rem_rank) begin
            rank_we = 1'b1;
            rank_wa = r_pidx;
            rank_wd = r_rank_rd - SW'(1);
        end
    end

    // entry and rank memories, registered read
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[r_idx[SW-1:0]] <= r_key;
        end
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        r_ent_rd  <= ent_mem[rd_addr];
        r_rank_rd <= rank_mem[rd_addr];
    end

    // shared compare and score unit for the entry read last cycle
    always_comb begin
        n_match = r_valid[r_pidx] && (r_ent_rd.protocol == r_key.protocol);
        n_score = '0;
        if (r_ent_rd.sport != '0) begin
            if (r_ent_rd.sport == r_key.sport) n_score = n_score + 3'd1;
            else n_match = 1'b0;
        end
        if (r_ent_rd.saddr != '0) begin
            if (r_ent_rd.saddr == r_key.saddr) n_score = n_score + 3'd1;
            else n_match = 1'b0;
        end
        if (r_ent_rd.dport != '0) begin
            if (r_ent_rd.dport == r_key.dport) n_score = n_score + 3'd1;
            else n_match = 1'b0;
        end
        if (r_ent_rd.daddr != '0) begin
            if (r_ent_rd.daddr == r_key.daddr) n_score = n_score + 3'd1;
            else n_match = 1'b0;
        end
        n_take_full = n_match && (n_score == r_full)
                      && (!r_hit_full || r_rank_rd < r_full_rank);
        n_take_best = n_match && (n_score != r_full) && (n_score != '0)
                      && (!r_hit_best || n_score > r_best_score
                          || (n_score == r_best_score && r_rank_rd < r_best_rank));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key.protocol <= i_key_protocol;
                        r_key.sport    <= i_key_sport;
                        r_key.saddr    <= i_key_saddr;
                        r_key.dport    <= i_key_dport;
                        r_key.daddr    <= i_key_daddr;
                        r_full         <= i_full_score;
                        r_rem_slot     <= handle_x[SW-1:0];
                        r_idx          <= '0;
                        r_pend         <= 1'b0;
                        r_hit_full     <= 1'b0;
                        r_hit_best     <= 1'b0;
                        r_out_slot     <= '0;
                        r_out_status   <= wsmt_pkg::ST_OK;
                        case (i_operation)
                            wsmt_pkg::OP_ADD: begin
                                if (r_count == CW'(TABLE_DEPTH)) begin
                                    r_out_status <= wsmt_pkg::ST_FULL;
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_ADD_SCAN;
                                end
                            end
                            wsmt_pkg::OP_REMOVE: begin
                                if (handle_ok) begin
                                    r_state <= S_REM_CAP;
                                end else begin
                                    r_out_status <= wsmt_pkg::ST_ABSENT;
                                    r_out_valid  <= 1'b1;
                                end
                            end
                            wsmt_pkg::OP_FIND: begin
                                r_state <= S_FIND_WALK;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                // look for the lowest free slot, one valid bit per cycle
                S_ADD_SCAN: begin
                    if (scan_free) begin
                        r_valid[r_idx[SW-1:0]] <= 1'b1;
                        r_count      <= r_count + CW'(1);
                        r_out_slot   <= 4'({{4{1'b0}}, r_idx[SW-1:0]});
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                // rank of the removed slot is on the read port now
                S_REM_CAP: begin
                    r_rem_rank          <= r_rank_rd;
                    r_valid[r_rem_slot] <= 1'b0;
                    r_count             <= r_count - CW'(1);
                    r_state             <= S_REM_WALK;
                end
                // close the gap in the ranks behind the removed one
                S_REM_WALK: begin
                    r_pend <= walk_in_range;
                    r_pidx <= r_idx[SW-1:0];
                    if (walk_in_range) begin
                        r_idx <= r_idx + CW'(1);
                    end else if (!r_pend) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                // score every entry and keep the winners
                S_FIND_WALK: begin
                    r_pend <= walk_in_range;
                    r_pidx <= r_idx[SW-1:0];
                    if (walk_in_range) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pend && n_take_full) begin
                        r_hit_full  <= 1'b1;
                        r_full_rank <= r_rank_rd;
                        r_full_slot <= r_pidx;
                    end
                    if (r_pend && n_take_best) begin
                        r_hit_best   <= 1'b1;
                        r_best_score <= n_score;
                        r_best_rank  <= r_rank_rd;
                        r_best_slot  <= r_pidx;
                    end
                    if (!walk_in_range && !r_pend) begin
                        if (r_hit_full) begin
                            r_out_slot <= 4'({{4{1'b0}}, r_full_slot});
                        end else if (r_hit_best) begin
                            r_out_slot <= 4'({{4{1'b0}}, r_best_slot});
                        end else begin
                            r_out_status <= wsmt_pkg::ST_MISS;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_slot = r_out_slot;

    // the entry count always equals the number of valid slots
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count out of step with valid bits");

    // an accepted beat either starts work or answers in the next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted command neither busy nor answered");

    // a result is only shown once the sequencer is back at idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // table full is reported only when every slot is taken
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == wsmt_pkg::ST_FULL) |-> (r_count == CW'(TABLE_DEPTH)))
        else $error("table full reported with free slots");

    // a remove walk never runs with the removed slot still valid
    a_removed_slot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM_WALK) |-> !r_valid[r_rem_slot])
        else $error("removed slot still valid during renumbering");

endmodule
